[src/sslf_pkg.sv]
// Shared constants, types and helpers for the step/stair/lift detector.
// Used by every module of the block; depends on nothing.
package sslf_pkg;

    // Sample and magnitude geometry
    localparam int SAMPLE_BITS = 16;
    localparam int SQ_BITS     = 2 * SAMPLE_BITS;            // sum of three squares fits
    localparam int ROOT_BITS   = SAMPLE_BITS;
    localparam int REM_BITS    = ROOT_BITS + 1;              // remainder <= 2 * root
    localparam int STEP_CNT_W  = $clog2(SAMPLE_BITS + 1);

    // Window and counters
    localparam int VAL_BITS    = 16;
    localparam int WINDOW_LEN  = 10;
    localparam int PTR_W       = $clog2(WINDOW_LEN);
    localparam int SUM_W       = VAL_BITS + $clog2(WINDOW_LEN);
    localparam int CNT_BITS    = 16;
    localparam int RUN_BITS    = 4;

    // Stream word widths
    localparam int IN_DATA_W   = 3 * SAMPLE_BITS;
    localparam int OUT_FIELD_W = 4 * CNT_BITS + 3;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STAIR_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET_THR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_FILL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFT_THR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFT_CONF  = 3'd5;

    // Register reset values (8192 counts per g)
    localparam logic [VAL_BITS-1:0] RST_STEP_THR  = 16'd9830;   // 1.2 g
    localparam logic [VAL_BITS-1:0] RST_STAIR_THR = 16'd10977;  // 1.34 g
    localparam logic [VAL_BITS-1:0] RST_QUIET_THR = 16'd9503;   // 1.16 g
    localparam logic [VAL_BITS-1:0] RST_IDLE_FILL = 16'd8192;   // 1.00 g
    localparam logic [VAL_BITS-1:0] RST_LIFT_THR  = 16'd8602;   // 1.05 g
    localparam logic [RUN_BITS-1:0] RST_LIFT_CONF = 4'd3;

    typedef struct packed {
        logic [VAL_BITS-1:0] step_threshold;
        logic [VAL_BITS-1:0] stair_threshold;
        logic [VAL_BITS-1:0] quiet_threshold;
        logic [VAL_BITS-1:0] idle_fill;
        logic [VAL_BITS-1:0] lift_threshold;
        logic [RUN_BITS-1:0] lift_confirm;
    } cfg_t;

    typedef struct packed {
        logic                lift_seen;
        logic                stair_seen;
        logic                step_seen;
        logic [VAL_BITS-1:0] magnitude;
        logic [CNT_BITS-1:0] lift_total;
        logic [CNT_BITS-1:0] stair_total;
        logic [CNT_BITS-1:0] step_total;
    } res_t;

    // Saturating counter increment
    function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] c);
        sat_inc = (c == {CNT_BITS{1'b1}}) ? c : c + 1'b1;
    endfunction

endpackage

[src/sslf_sqsum.sv]
// Bit-serial sum of squares of the three axes, one multiplier bit per cycle.
// Depends on sslf_pkg.
module sslf_sqsum (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [sslf_pkg::SAMPLE_BITS-1:0]    ax,
    input  logic [sslf_pkg::SAMPLE_BITS-1:0]    ay,
    input  logic [sslf_pkg::SAMPLE_BITS-1:0]    az,
    output logic                                done,
    output logic [sslf_pkg::SQ_BITS-1:0]        sum
);

    localparam int S  = sslf_pkg::SAMPLE_BITS;
    localparam int SQ = sslf_pkg::SQ_BITS;

    logic [S-1:0]  mx_reg, my_reg, mz_reg;     // multiplicands
    logic [S-1:0]  bx_reg, by_reg, bz_reg;     // multiplier bits, MSB first
    logic [SQ-1:0] acc_reg, acc_next;
    logic [sslf_pkg::STEP_CNT_W-1:0] cnt_reg;
    logic          done_reg;

    function automatic logic [S-1:0] abs_val(input logic [S-1:0] v);
        abs_val = v[S-1] ? (~v + 1'b1) : v;
    endfunction

    // Horner step: shift the partial sum, add the selected multiplicands
    always_comb begin
        acc_next = {acc_reg[SQ-2:0], 1'b0}
                 + (bx_reg[S-1] ? SQ'(mx_reg) : '0)
                 + (by_reg[S-1] ? SQ'(my_reg) : '0)
                 + (bz_reg[S-1] ? SQ'(mz_reg) : '0);
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == sslf_pkg::STEP_CNT_W'(1)) && !start;
            if (start) begin
                cnt_reg <= sslf_pkg::STEP_CNT_W'(S);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            mx_reg  <= abs_val(ax);
            my_reg  <= abs_val(ay);
            mz_reg  <= abs_val(az);
            bx_reg  <= abs_val(ax);
            by_reg  <= abs_val(ay);
            bz_reg  <= abs_val(az);
            acc_reg <= '0;
        end else if (cnt_reg != '0) begin
            acc_reg <= acc_next;
            bx_reg  <= {bx_reg[S-2:0], 1'b0};
            by_reg  <= {by_reg[S-2:0], 1'b0};
            bz_reg  <= {bz_reg[S-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign sum  = acc_reg;

endmodule

[src/sslf_isqrt.sv]
// Digit-serial integer square root, one root bit per cycle (restoring).
// Depends on sslf_pkg.
module sslf_isqrt (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [sslf_pkg::SQ_BITS-1:0]        radicand,
    output logic                                done,
    output logic [sslf_pkg::ROOT_BITS-1:0]      root
);

    localparam int SQ = sslf_pkg::SQ_BITS;
    localparam int R  = sslf_pkg::ROOT_BITS;
    localparam int RM = sslf_pkg::REM_BITS;

    logic [SQ-1:0]   rad_reg;
    logic [RM-1:0]   rem_reg, rem_next;
    logic [R-1:0]    root_reg;
    logic [RM+1:0]   rem_sh, trial, rem_diff;
    logic            ge;
    logic [sslf_pkg::STEP_CNT_W-1:0] cnt_reg;
    logic            done_reg;

    // Bring down two radicand bits, try root*4+1
    always_comb begin
        rem_sh   = {rem_reg, rad_reg[SQ-1 -: 2]};
        trial    = {1'b0, root_reg, 2'b01};
        ge       = rem_sh >= trial;
        rem_diff = rem_sh - trial;
        rem_next = ge ? rem_diff[RM-1:0] : rem_sh[RM-1:0];
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == sslf_pkg::STEP_CNT_W'(1)) && !start;
            if (start) begin
                cnt_reg <= sslf_pkg::STEP_CNT_W'(R);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cnt_reg != '0) begin
            rad_reg  <= {rad_reg[SQ-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= {root_reg[R-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

[src/sslf_track.sv]
// Threshold tests, sliding window, lift run tracking and saturating counters.
// Depends on sslf_pkg.
module sslf_track (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  sslf_pkg::cfg_t                  cfg,
    input  logic                            sample_en,   // magnitude is ready
    input  logic [sslf_pkg::VAL_BITS-1:0]   mag,
    input  logic                            commit_en,   // finish the item
    input  logic                            clear_op,
    output sslf_pkg::res_t                  res
);

    localparam int W  = sslf_pkg::VAL_BITS;
    localparam int SW = sslf_pkg::SUM_W;
    localparam int PW = sslf_pkg::PTR_W;
    localparam int RB = sslf_pkg::RUN_BITS;
    localparam int CB = sslf_pkg::CNT_BITS;
    localparam int WL = sslf_pkg::WINDOW_LEN;

    logic [W-1:0]  win_reg [WL];
    logic [PW-1:0] ptr_reg, ptr_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic [RB-1:0] run_reg, run_mid, run_inc, confirm;
    logic          grace_reg;
    logic [CB-1:0] steps_reg, stairs_reg, lifts_reg;
    logic [CB-1:0] steps_new, stairs_new, lifts_new;
    logic [W-1:0]  mag_reg;
    logic          step_seen_reg, stair_seen_reg;

    logic          step_hit, stair_hit;
    logic [W-1:0]  fill;
    logic [SW-1:0] lift_limit;
    logic          lift_like, trip, keep;

    // Sample stage: threshold tests and new window value
    always_comb begin
        step_hit  = mag >= cfg.step_threshold;
        stair_hit = mag >= cfg.stair_threshold;
        fill      = cfg.idle_fill;
        if (step_hit) begin
            fill = '0;
        end
        if (mag <= cfg.quiet_threshold) begin
            fill = mag;
        end
        sum_next = sum_reg - SW'(win_reg[ptr_reg]) + SW'(fill);
        ptr_next = (ptr_reg == PW'(WL - 1)) ? '0 : ptr_reg + 1'b1;
    end

    // Commit stage: average test and lift run
    always_comb begin
        lift_limit = SW'(cfg.lift_threshold) * SW'(WL);
        lift_like  = sum_reg >= lift_limit;
        run_inc    = run_reg + 1'b1;
        priority if (lift_like) begin
            run_mid = run_inc;
        end else if (grace_reg) begin
            run_mid = run_reg;
        end else begin
            run_mid = '0;
        end
        confirm    = (cfg.lift_confirm == '0) ? RB'(1) : cfg.lift_confirm;
        trip       = run_mid >= confirm;
        keep       = !clear_op;
        steps_new  = step_seen_reg  ? sslf_pkg::sat_inc(steps_reg)  : steps_reg;
        stairs_new = stair_seen_reg ? sslf_pkg::sat_inc(stairs_reg) : stairs_reg;
        lifts_new  = trip           ? sslf_pkg::sat_inc(lifts_reg)  : lifts_reg;
    end

    // Result word for the item being committed
    always_comb begin
        res.step_total  = keep ? steps_new  : '0;
        res.stair_total = keep ? stairs_new : '0;
        res.lift_total  = keep ? lifts_new  : '0;
        res.magnitude   = keep ? mag_reg    : '0;
        res.step_seen   = keep && step_seen_reg;
        res.stair_seen  = keep && stair_seen_reg;
        res.lift_seen   = keep && trip;
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WL; i++) begin
                win_reg[i] <= '0;
            end
            ptr_reg    <= '0;
            sum_reg    <= '0;
            run_reg    <= '0;
            grace_reg  <= 1'b0;
            steps_reg  <= '0;
            stairs_reg <= '0;
            lifts_reg  <= '0;
        end else if (sample_en) begin
            win_reg[ptr_reg] <= fill;
            sum_reg          <= sum_next;
            ptr_reg          <= ptr_next;
        end else if (commit_en) begin
            if (clear_op) begin
                steps_reg  <= '0;
                stairs_reg <= '0;
                lifts_reg  <= '0;
            end else begin
                steps_reg  <= steps_new;
                stairs_reg <= stairs_new;
                lifts_reg  <= lifts_new;
                grace_reg  <= lift_like;
                run_reg    <= trip ? '0 : run_mid;
                // Lift trip empties the window
                if (trip) begin
                    for (int i = 0; i < WL; i++) begin
                        win_reg[i] <= '0;
                    end
                    sum_reg <= '0;
                end
            end
        end
    end

    // Per-sample results held for the commit stage
    always_ff @(posedge aclk) begin
        if (sample_en) begin
            mag_reg        <= mag;
            step_seen_reg  <= step_hit;
            stair_seen_reg <= stair_hit;
        end
    end

endmodule

[src/step_stair_lift_detector.sv]
// Step, stair and lift detector for three-axis accelerometer samples.
// Input words enter on s_*, result words leave on m_*, settings on cfg_*.
// A sample word (s_tuser = 0) has its three axes squared and summed, one
// multiplier bit per cycle, then reduced by a bit-serial square root,
// then the window and counters are updated. A clear word (s_tuser = 1)
// zeroes the step, stair and lift counters and returns an all-zero result.
// One word is in work at a time: a sample word passes the squaring unit,
// the root unit, the window update and the commit step in order; a clear
// word goes straight to the commit step.
// s_tready is high only while no word is in work; a new word may be taken
// while the previous result still sits in the output register.
// If the receiver stalls, the finished word waits until the output register
// frees up; later words wait behind it.
// Reset (aresetn low, synchronous) loads the default thresholds, empties
// the window and zeroes all counters. cfg_ready is always high; writes are
// meant for idle periods. Unknown register indexes are ignored.
// Depends on sslf_pkg, sslf_sqsum, sslf_isqrt and sslf_track.
module step_stair_lift_detector (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Sample channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sslf_pkg::IN_DATA_W-1:0]      s_tdata,   // accel_x, accel_y, accel_z
    input  logic [0:0]                          s_tuser,   // op
    // Result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // step_total, stair_total, lift_total, magnitude, step_seen, stair_seen,
    // lift_seen, zero pad
    output logic [sslf_pkg::OUT_DATA_W-1:0]     m_tdata,
    // Configuration channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sslf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sslf_pkg::VAL_BITS-1:0]       cfg_data
);

    localparam int S = sslf_pkg::SAMPLE_BITS;

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SQR  = 2'd1;
    localparam logic [1:0] ST_ROOT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       clear_op_reg;
    logic       accept, sq_start, sq_done, root_start, root_done, sample_en, commit;
    logic [sslf_pkg::SQ_BITS-1:0]   sq_sum;
    logic [sslf_pkg::ROOT_BITS-1:0] root;
    sslf_pkg::cfg_t cfg_reg;
    sslf_pkg::res_t res;
    logic                           m_tvalid_reg;
    logic [sslf_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    // Handshakes
    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign sq_start   = accept && !s_tuser[0];
    assign root_start = (state_reg == ST_SQR) && sq_done;
    assign sample_en  = (state_reg == ST_ROOT) && root_done;
    assign commit     = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);
    assign cfg_ready  = 1'b1;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = s_tuser[0] ? ST_DONE : ST_SQR;
                end
            end
            ST_SQR: begin
                if (sq_done) begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (root_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            clear_op_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                clear_op_reg <= s_tuser[0];
            end
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_threshold  <= sslf_pkg::RST_STEP_THR;
            cfg_reg.stair_threshold <= sslf_pkg::RST_STAIR_THR;
            cfg_reg.quiet_threshold <= sslf_pkg::RST_QUIET_THR;
            cfg_reg.idle_fill       <= sslf_pkg::RST_IDLE_FILL;
            cfg_reg.lift_threshold  <= sslf_pkg::RST_LIFT_THR;
            cfg_reg.lift_confirm    <= sslf_pkg::RST_LIFT_CONF;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                sslf_pkg::CFG_STEP_THR:  cfg_reg.step_threshold  <= cfg_data;
                sslf_pkg::CFG_STAIR_THR: cfg_reg.stair_threshold <= cfg_data;
                sslf_pkg::CFG_QUIET_THR: cfg_reg.quiet_threshold <= cfg_data;
                sslf_pkg::CFG_IDLE_FILL: cfg_reg.idle_fill       <= cfg_data;
                sslf_pkg::CFG_LIFT_THR:  cfg_reg.lift_threshold  <= cfg_data;
                sslf_pkg::CFG_LIFT_CONF: cfg_reg.lift_confirm    <=
                                             cfg_data[sslf_pkg::RUN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Serial units
    sslf_sqsum u_sqsum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .ax       (s_tdata[S-1:0]),
        .ay       (s_tdata[2*S-1:S]),
        .az       (s_tdata[3*S-1:2*S]),
        .done     (sq_done),
        .sum      (sq_sum)
    );

    sslf_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start),
        .radicand (sq_sum),
        .done     (root_done),
        .root     (root)
    );

    // Root never exceeds the magnitude range for three 16-bit axes
    sslf_track u_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .sample_en (sample_en),
        .mag       (sslf_pkg::VAL_BITS'(root)),
        .commit_en (commit),
        .clear_op  (clear_op_reg),
        .res       (res)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_tdata_reg <= sslf_pkg::OUT_DATA_W'({res.lift_seen, res.stair_seen,
                                                  res.step_seen, res.magnitude,
                                                  res.lift_total, res.stair_total,
                                                  res.step_total});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[src/sslf_chk.sv]
// Port-level checks for the step/stair/lift detector, bound to its top level.
// Depends on sslf_pkg and step_stair_lift_detector.
module sslf_chk (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [sslf_pkg::OUT_DATA_W-1:0]  m_tdata
);

    // Stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // Reset empties the output register
    a_rst_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // One word in work at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // A counted step shows in the step total
    a_step_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[64] |-> m_tdata[15:0] != 16'd0)
        else $error("step seen with zero step total");

    // A completed lift shows in the lift total
    a_lift_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[66] |-> m_tdata[47:32] != 16'd0)
        else $error("lift seen with zero lift total");

endmodule

bind step_stair_lift_detector sslf_chk u_sslf_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/sv/sslf_tb_pkg.sv]
// Word kind codes shared by the detector testbench top and its checker.
// Depends on nothing.
package sslf_tb_pkg;

    // s_tuser values: sample word or counter clear
    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_CLEAR  = 1'b1
    } op_e;

endpackage

[tb/sv/step_stair_lift_checker.sv]
// Checker for the step/stair/lift detector: tracks settings writes, predicts a
// result word per accepted input word and compares it with the m_* stream.
// Depends on sslf_pkg and sslf_tb_pkg.
module step_stair_lift_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [sslf_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic [0:0]                       s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [sslf_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [sslf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sslf_pkg::VAL_BITS-1:0]    cfg_data,
    output int                               mismatch_count,
    output int                               results_due
);
    import sslf_pkg::*;
    import sslf_tb_pkg::*;

    // Mirror of the block's settings and tracking state
    cfg_t                settings;
    logic [VAL_BITS-1:0] win_vals [WINDOW_LEN];
    int unsigned         win_ptr;
    int unsigned         win_sum;
    int unsigned         lift_run;
    logic                miss_grace;
    logic [CNT_BITS-1:0] steps;
    logic [CNT_BITS-1:0] stairs;
    logic [CNT_BITS-1:0] lifts;

    res_t due_results [$];
    int   errors = 0;

    function automatic logic [CNT_BITS-1:0] count_up(input logic [CNT_BITS-1:0] c);
        return (c == {CNT_BITS{1'b1}}) ? c : c + 1'b1;
    endfunction

    // Square of one axis, taken on the absolute value
    function automatic logic [63:0] axis_energy(input logic signed [SAMPLE_BITS-1:0] a);
        longint      s;
        logic [63:0] m;
        s = a;
        if (s < 0) s = -s;
        m = s;
        return m * m;
    endfunction

    // Exact floor square root, two bits per step
    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] rest;
        logic [63:0] root;
        logic [63:0] probe;
        rest  = n;
        root  = '0;
        probe = 64'h1 << 62;
        while (probe > rest) probe = probe >> 2;
        while (probe != 0) begin
            if (rest >= root + probe) begin
                rest = rest - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Advance the mirrored state by one input word and return its result word
    function automatic res_t predict_word(input op_e op, input logic [IN_DATA_W-1:0] d);
        res_t                r;
        logic [63:0]         energy;
        logic [63:0]         root;
        logic [VAL_BITS-1:0] mag;
        logic [VAL_BITS-1:0] fill;
        int unsigned         need;
        r = '0;
        if (op == OP_CLEAR) begin
            steps  = '0;
            stairs = '0;
            lifts  = '0;
            return r;
        end
        energy = axis_energy(d[SAMPLE_BITS-1:0])
               + axis_energy(d[2*SAMPLE_BITS-1:SAMPLE_BITS])
               + axis_energy(d[3*SAMPLE_BITS-1:2*SAMPLE_BITS]);
        root = floor_sqrt(energy);
        mag  = (root > 64'd65535) ? 16'hFFFF : root[VAL_BITS-1:0];

        // step and stair tests are independent; a quiet magnitude wins the slot
        fill = settings.idle_fill;
        if (mag >= settings.step_threshold) begin
            r.step_seen = 1'b1;
            steps       = count_up(steps);
            fill        = '0;
        end
        if (mag >= settings.stair_threshold) begin
            r.stair_seen = 1'b1;
            stairs       = count_up(stairs);
        end
        if (mag <= settings.quiet_threshold) fill = mag;

        win_sum           = win_sum - win_vals[win_ptr] + fill;
        win_vals[win_ptr] = fill;
        win_ptr           = (win_ptr + 1) % WINDOW_LEN;

        // lift run with one miss of grace
        if (win_sum >= 32'(settings.lift_threshold) * WINDOW_LEN) begin
            lift_run   = lift_run + 1;
            miss_grace = 1'b1;
        end else if (miss_grace) begin
            miss_grace = 1'b0;
        end else begin
            lift_run = 0;
        end

        need = (settings.lift_confirm == 0) ? 1 : settings.lift_confirm;
        if (lift_run >= need) begin
            r.lift_seen = 1'b1;
            lifts       = count_up(lifts);
            lift_run    = 0;
            foreach (win_vals[i]) win_vals[i] = '0;
            win_sum = 0;
        end

        r.magnitude   = mag;
        r.step_total  = steps;
        r.stair_total = stairs;
        r.lift_total  = lifts;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        res_t got;
        res_t want;
        if (!aresetn) begin
            settings.step_threshold  = RST_STEP_THR;
            settings.stair_threshold = RST_STAIR_THR;
            settings.quiet_threshold = RST_QUIET_THR;
            settings.idle_fill       = RST_IDLE_FILL;
            settings.lift_threshold  = RST_LIFT_THR;
            settings.lift_confirm    = RST_LIFT_CONF;
            foreach (win_vals[i]) win_vals[i] = '0;
            win_ptr    = 0;
            win_sum    = 0;
            lift_run   = 0;
            miss_grace = 1'b0;
            steps      = '0;
            stairs     = '0;
            lifts      = '0;
            due_results.delete();
        end else begin
            // result word leaving the block
            if (m_tvalid && m_tready) begin
                got = res_t'(m_tdata[OUT_FIELD_W-1:0]);
                if (due_results.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result word: steps %0d stairs %0d lifts %0d mag %0d",
                                 got.step_total, got.stair_total, got.lift_total,
                                 got.magnitude);
                end else begin
                    want = due_results.pop_front();
                    if (got.step_total !== want.step_total
                            || got.stair_total !== want.stair_total
                            || got.lift_total !== want.lift_total
                            || got.magnitude !== want.magnitude
                            || got.step_seen !== want.step_seen
                            || got.stair_seen !== want.stair_seen
                            || got.lift_seen !== want.lift_seen) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch expected: steps %0d stairs %0d lifts %0d mag %0d seen %b%b%b",
                                     want.step_total, want.stair_total, want.lift_total,
                                     want.magnitude, want.step_seen, want.stair_seen,
                                     want.lift_seen);
                            $display("         actual:   steps %0d stairs %0d lifts %0d mag %0d seen %b%b%b",
                                     got.step_total, got.stair_total, got.lift_total,
                                     got.magnitude, got.step_seen, got.stair_seen,
                                     got.lift_seen);
                        end
                    end
                end
            end

            // settings write
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_STEP_THR:  settings.step_threshold  = cfg_data;
                    CFG_STAIR_THR: settings.stair_threshold = cfg_data;
                    CFG_QUIET_THR: settings.quiet_threshold = cfg_data;
                    CFG_IDLE_FILL: settings.idle_fill       = cfg_data;
                    CFG_LIFT_THR:  settings.lift_threshold  = cfg_data;
                    CFG_LIFT_CONF: settings.lift_confirm    = cfg_data[RUN_BITS-1:0];
                    default: ;
                endcase
            end

            // input word taken by the block
            if (s_tvalid && s_tready)
                due_results.push_back(predict_word(op_e'(s_tuser[0]), s_tdata));
        end
        results_due    <= due_results.size();
        mismatch_count <= errors;
    end

endmodule

[tb/sv/step_stair_lift_detector_tb.sv]
// Testbench top for step_stair_lift_detector: clock, reset, settings phases,
// sample stimulus and random flow control; the checker does the comparing.
// Depends on sslf_pkg, sslf_tb_pkg, step_stair_lift_checker and the block.
module step_stair_lift_detector_tb;
    import sslf_pkg::*;
    import sslf_tb_pkg::*;

    localparam int ITEMS_PER_PHASE = 96;
    localparam int PHASES          = 7;
    localparam int DRAIN_CYCLES    = 60;
    localparam int MAX_MAG         = 56755;   // all three axes at full scale

    typedef enum int {
        LIFT_LIKE,
        NEAR_ONE_G,
        STEP_LIKE,
        THRESH_EDGE,
        CLEAR_WORD,
        RAW_WORD
    } sample_kind_e;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [VAL_BITS-1:0]   cfg_data  = '0;

    int   mismatch_count;
    int   results_due;
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    cfg_t now_cfg;

    step_stair_lift_detector DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    step_stair_lift_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offer one word on s_* and hold it until the block takes it
    task automatic offer_word(input op_e op, input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stop sending and wait for every outstanding result word
    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic write_settings(input cfg_t c);
        put_reg(CFG_STEP_THR, c.step_threshold);
        put_reg(CFG_STAIR_THR, c.stair_threshold);
        put_reg(CFG_QUIET_THR, c.quiet_threshold);
        put_reg(CFG_IDLE_FILL, c.idle_fill);
        put_reg(CFG_LIFT_THR, c.lift_threshold);
        put_reg(CFG_LIFT_CONF, VAL_BITS'(c.lift_confirm));
        cfg_valid <= 1'b0;
        now_cfg = c;
    endtask

    function automatic cfg_t phase_settings(input int p);
        cfg_t c;
        c.step_threshold  = RST_STEP_THR;
        c.stair_threshold = RST_STAIR_THR;
        c.quiet_threshold = RST_QUIET_THR;
        c.idle_fill       = RST_IDLE_FILL;
        c.lift_threshold  = RST_LIFT_THR;
        c.lift_confirm    = RST_LIFT_CONF;
        case (p)
            0: ;
            1: begin
                // everything at the bottom: every sample steps, lift every 15
                c.step_threshold  = '0;
                c.stair_threshold = '0;
                c.quiet_threshold = '0;
                c.idle_fill       = '0;
                c.lift_threshold  = '0;
                c.lift_confirm    = 4'd15;
            end
            2: begin
                // everything at the top: window fills with idle value
                c.step_threshold  = 16'hFFFF;
                c.stair_threshold = 16'hFFFF;
                c.quiet_threshold = '0;
                c.idle_fill       = 16'hFFFF;
                c.lift_threshold  = 16'hFFFF;
                c.lift_confirm    = 4'd1;
            end
            3: c.lift_confirm = '0;   // zero confirm behaves as one
            4: begin
                c.step_threshold  = 16'($urandom_range(0, 65535));
                c.stair_threshold = 16'($urandom_range(0, 65535));
                c.quiet_threshold = 16'($urandom_range(0, 65535));
                c.idle_fill       = 16'($urandom_range(0, 65535));
                c.lift_threshold  = 16'($urandom_range(0, 65535));
                c.lift_confirm    = 4'($urandom_range(1, 15));
            end
            default: begin
                // plausible spread around 1 g, order of thresholds not enforced
                c.step_threshold  = 16'($urandom_range(8192, 12192));
                c.stair_threshold = 16'($urandom_range(7500, 13500));
                c.quiet_threshold = 16'($urandom_range(8192, 10192));
                c.idle_fill       = 16'($urandom_range(7000, 10000));
                c.lift_threshold  = 16'($urandom_range(8192, 9500));
                c.lift_confirm    = 4'($urandom_range(1, 15));
            end
        endcase
        return c;
    endfunction

    function automatic logic [15:0] raw_axis();
        case ($urandom_range(15))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Sample whose vector length is close to m (exact for m up to 32767 when noise is off)
    task automatic send_magnitude(input int m, input bit exact);
        int          a;
        int          b;
        int          c;
        int          rot;
        logic [15:0] ax [3];
        if (m > MAX_MAG) m = MAX_MAG;
        if (m < 0) m = 0;
        if (m <= 32767) begin
            a = m;
            b = 0;
        end else begin
            a = 32767;
            b = int'($sqrt(real'(m) * real'(m) - 32767.0 * 32767.0));
        end
        c = 0;
        if (!exact && $urandom_range(1)) begin
            b = b + $urandom_range(0, 300);
            c = $urandom_range(0, 300);
        end
        if (b > 32767) b = 32767;
        if ($urandom_range(1)) a = -a;
        if ($urandom_range(1)) b = -b;
        if ($urandom_range(1)) c = -c;
        rot = $urandom_range(2);
        ax[rot]           = 16'(a);
        ax[(rot + 1) % 3] = 16'(b);
        ax[(rot + 2) % 3] = 16'(c);
        offer_word(OP_SAMPLE, ax[0], ax[1], ax[2]);
    endtask

    task automatic send_kind(input sample_kind_e k);
        int t;
        case (k)
            LIFT_LIKE:
                send_magnitude($urandom_range(now_cfg.lift_threshold, now_cfg.quiet_threshold),
                               1'b0);
            NEAR_ONE_G:
                send_magnitude($urandom_range(7800, 8700), 1'b0);
            STEP_LIKE:
                send_magnitude(now_cfg.step_threshold + $urandom_range(0, 4000), 1'b0);
            THRESH_EDGE: begin
                case ($urandom_range(3))
                    0:       t = now_cfg.step_threshold;
                    1:       t = now_cfg.stair_threshold;
                    2:       t = now_cfg.quiet_threshold;
                    default: t = now_cfg.lift_threshold;
                endcase
                t = t + int'($urandom_range(2)) - 1;
                send_magnitude(t, 1'b1);
            end
            CLEAR_WORD:
                offer_word(OP_CLEAR, raw_axis(), raw_axis(), raw_axis());
            default:
                offer_word(OP_SAMPLE, raw_axis(), raw_axis(), raw_axis());
        endcase
    endtask

    // Random bouts: mostly lift-like runs with stray misses, some walking,
    // some pure noise with clears and full-range axes
    task automatic run_phase();
        int           sent;
        int           len;
        int           r;
        int           p;
        sample_kind_e k;
        sent = 0;
        while (sent < ITEMS_PER_PHASE) begin
            r = $urandom_range(99);
            if (r < 60) begin
                len = $urandom_range(10, 24);
                repeat (len) begin
                    if ($urandom_range(99) < 85)
                        k = LIFT_LIKE;
                    else
                        k = sample_kind_e'($urandom_range(NEAR_ONE_G, THRESH_EDGE));
                    send_kind(k);
                end
            end else if (r < 85) begin
                len = $urandom_range(4, 12);
                repeat (len) begin
                    p = $urandom_range(9);
                    k = (p < 5) ? STEP_LIKE : (p < 9) ? NEAR_ONE_G : THRESH_EDGE;
                    send_kind(k);
                end
            end else begin
                len = $urandom_range(1, 6);
                repeat (len) send_kind(sample_kind_e'($urandom_range(LIFT_LIKE, RAW_WORD)));
            end
            sent = sent + len;
        end
    endtask

    initial begin : stimulus
        int p;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        now_cfg = phase_settings(0);

        // directed: axis extremes, threshold boundaries, clear, one lift trip
        offer_word(OP_SAMPLE, 16'h0000, 16'h0000, 16'h0000);
        offer_word(OP_SAMPLE, 16'h7FFF, 16'h0000, 16'h0000);
        offer_word(OP_SAMPLE, 16'h8000, 16'h0000, 16'h0000);
        offer_word(OP_SAMPLE, 16'h0000, 16'h8000, 16'h0000);
        offer_word(OP_SAMPLE, 16'h0000, 16'h0000, 16'h7FFF);
        offer_word(OP_SAMPLE, 16'h8000, 16'h8000, 16'h8000);
        offer_word(OP_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        offer_word(OP_SAMPLE, 16'hFFFF, 16'h0001, 16'hFFFF);
        offer_word(OP_SAMPLE, 16'h0000, 16'h0000, RST_STEP_THR);
        offer_word(OP_SAMPLE, 16'h0000, 16'h0000, RST_STEP_THR - 1'b1);
        offer_word(OP_SAMPLE, 16'h0000, 16'h0000, RST_STAIR_THR);
        offer_word(OP_SAMPLE, 16'h0000, 16'h0000, RST_QUIET_THR);
        offer_word(OP_SAMPLE, 16'h0000, 16'h0000, RST_QUIET_THR + 1'b1);
        offer_word(OP_CLEAR, 16'h1234, 16'hFEDC, 16'h8000);
        repeat (12) offer_word(OP_SAMPLE, 16'h0000, 16'h0000, 16'd9400);

        for (p = 0; p < PHASES; p++) begin
            quiesce();
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                1: begin send_idle_pct = 50; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 50; end
                default: begin send_idle_pct = 20; stall_pct <= 20; end
            endcase
            write_settings(phase_settings(p));
            run_phase();
        end

        quiesce();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[filelist.f]
src/sslf_pkg.sv
src/sslf_sqsum.sv
src/sslf_isqrt.sv
src/sslf_track.sv
src/step_stair_lift_detector.sv
src/sslf_chk.sv
tb/sv/sslf_tb_pkg.sv
tb/sv/step_stair_lift_checker.sv
tb/sv/step_stair_lift_detector_tb.sv
